/* sv/edd_pkg.sv */
// ----------------------------------------------------------------------------
// edd_pkg: shared definitions for the error diffusion dither unit
// Widths, register map, register reset values and black/white pixel levels.
// ----------------------------------------------------------------------------
package edd_pkg;

  localparam int PIX_W   = 8;
  localparam int FW_W    = 11;
  localparam int FH_W    = 16;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  // register byte addresses
  localparam logic [PADDR_W-1:0] ADDR_FRAME_WIDTH  = 3'd0;
  localparam logic [PADDR_W-1:0] ADDR_FRAME_HEIGHT = 3'd4;

  localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 11'd1024;
  localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 16'd1;

  localparam logic [PIX_W-1:0] PIX_BLACK = 8'd0;
  localparam logic [PIX_W-1:0] PIX_WHITE = 8'd255;

endpackage

/* sv/error_diffusion_dither_unit.sv */
// ----------------------------------------------------------------------------
// error_diffusion_dither_unit: Floyd-Steinberg binarizer for grey pixel streams
// Raster-order 8-bit pixels in, 0/255 pixels with row and frame marks out.
// ----------------------------------------------------------------------------
// Takes one pixel per clock while the output side is not stalled and returns one
// result per pixel. At the input transfer the next-row error of the pixel's
// column is read from a MAX_WIDTH-entry RAM; as the pixel moves on to the output
// register, the left carry is added, the sum is thresholded and the finished
// error of the column to its left is written back. The left 7/16 carry loop
// sets the clock. The last column's error waits in a holding register and is
// written at the first pixel of the next row, when the write port is free. No
// clearing pass: a fill count marks which columns were written in the current
// frame, so the unit takes pixels straight out of reset and across frame ends.
// Errors are fixed point with FRAC_BITS fractional bits, FRAC_BITS+12 wide.
module error_diffusion_dither_unit #(
  parameter int MAX_WIDTH = 1024,
  parameter int FRAC_BITS = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // pixel input
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [edd_pkg::PIX_W-1:0]   pixel_in_i,
  // result output
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [edd_pkg::PIX_W-1:0]   pixel_out_o,
  output logic                        end_of_row_o,
  output logic                        end_of_frame_o,
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [edd_pkg::PADDR_W-1:0] paddr,
  input  logic [edd_pkg::PDATA_W-1:0] pwdata,
  output logic [edd_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);

  import edd_pkg::*;

  localparam int CW   = $clog2(MAX_WIDTH);      // column index
  localparam int WW   = $clog2(MAX_WIDTH + 1);  // fill count
  localparam int CMPW = ((WW > FW_W) ? WW : FW_W) + 1;
  localparam int EW   = FRAC_BITS + 12;         // error word
  localparam int PADW = EW - PIX_W - FRAC_BITS;

  localparam logic signed [EW-1:0] THRESH = EW'(128 << FRAC_BITS);
  localparam logic signed [EW-1:0] WHITE  = EW'(255 << FRAC_BITS);
  localparam logic [CMPW-1:0]      MAXW   = CMPW'(MAX_WIDTH);

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [FW_W-1:0] frame_width_q;
  logic [FH_W-1:0] frame_height_q;
  logic            cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= FRAME_WIDTH_RST;
      frame_height_q <= FRAME_HEIGHT_RST;
    end else if (cfg_wr) begin
      unique case (paddr)
        ADDR_FRAME_WIDTH:  frame_width_q  <= pwdata[FW_W-1:0];
        ADDR_FRAME_HEIGHT: frame_height_q <= pwdata[FH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr)
      ADDR_FRAME_WIDTH:  prdata = PDATA_W'(frame_width_q);
      ADDR_FRAME_HEIGHT: prdata = PDATA_W'(frame_height_q);
      default:           prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // handshake and position counters (input side)
  // --------------------------------------------------------------------------
  logic            s1_valid_q;
  logic [PIX_W-1:0] pix1_q;
  logic [CW-1:0]   col1_q;
  logic            lc1_q, lr1_q;
  logic            advance, accept;
  logic [CW-1:0]   col_cnt_q;
  logic [FH_W-1:0] row_cnt_q;
  logic [CMPW-1:0] w_eff;
  logic [FH_W:0]   h_eff;
  logic            last_col, last_row;
  logic            out_valid_q;

  assign advance    = s1_valid_q & (~out_valid_q | out_ready_i);
  assign in_ready_o = ~s1_valid_q | advance;
  assign accept     = in_valid_i & in_ready_o;

  always_comb begin
    if (frame_width_q == '0) begin
      w_eff = CMPW'(1);
    end else if (CMPW'(frame_width_q) > MAXW) begin
      w_eff = MAXW;
    end else begin
      w_eff = CMPW'(frame_width_q);
    end
    h_eff    = (frame_height_q == '0) ? (FH_W+1)'(1) : {1'b0, frame_height_q};
    last_col = (CMPW'(col_cnt_q) + CMPW'(1)) >= w_eff;
    last_row = ({1'b0, row_cnt_q} + (FH_W+1)'(1)) >= h_eff;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_cnt_q  <= '0;
      row_cnt_q  <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        if (last_col) begin
          col_cnt_q <= '0;
          row_cnt_q <= last_row ? '0 : row_cnt_q + FH_W'(1);
        end else begin
          col_cnt_q <= col_cnt_q + CW'(1);
        end
      end
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (advance) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pix1_q <= pixel_in_i;
      col1_q <= col_cnt_q;
      lc1_q  <= last_col;
      lr1_q  <= last_row;
    end
  end

  // --------------------------------------------------------------------------
  // next-row error RAM
  // --------------------------------------------------------------------------
  logic          ram_we;
  logic [CW-1:0] ram_waddr;
  logic [EW-1:0] ram_wdata;
  logic [EW-1:0] ram_rdata;

  edd_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_WIDTH)
  ) u_err_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (accept),
    .raddr_i (col_cnt_q),
    .rdata_o (ram_rdata)
  );

  // --------------------------------------------------------------------------
  // diffusion datapath (between input and output registers)
  // --------------------------------------------------------------------------
  logic signed [EW-1:0]   carry_q, below_here_q, below_ahead_q;
  logic                   tail_valid_q;
  logic [CW-1:0]          tail_col_q;
  logic signed [EW-1:0]   tail_data_q;
  logic                   fwd_hit_q;
  logic signed [EW-1:0]   fwd_data_q;
  logic [WW-1:0]          fill_q;

  logic signed [EW-1:0]   below_rd, v, e, t7, t5, t3, t1, cur, wr_left;
  logic signed [EW+2:0]   ex;
  logic                   white, frame_end, prim_we, tail_set;
  logic [WW-1:0]          fill_d;

  always_comb begin
    if (tail_valid_q && tail_col_q == col1_q) begin
      below_rd = tail_data_q;
    end else if (fwd_hit_q) begin
      below_rd = fwd_data_q;
    end else if (WW'(col1_q) < fill_q) begin
      below_rd = ram_rdata;
    end else begin
      below_rd = '0;
    end

    v     = {{PADW{1'b0}}, pix1_q, {FRAC_BITS{1'b0}}} + carry_q + below_rd;
    white = ~(v < THRESH);
    e     = white ? (v - WHITE) : v;
    ex    = (EW+3)'(e);

    // floor(e*k/16) via shift-and-add and an arithmetic shift
    t7 = EW'(((ex <<< 3) - ex) >>> 4);
    t5 = EW'(((ex <<< 2) + ex) >>> 4);
    t3 = EW'(((ex <<< 1) + ex) >>> 4);
    t1 = EW'(ex >>> 4);

    wr_left   = below_here_q + t3;
    cur       = below_ahead_q + t5;
    frame_end = lc1_q & lr1_q;
    prim_we   = ~lr1_q & (col1_q != '0);
    tail_set  = ~lr1_q & lc1_q;

    // the column left of us owns the port; the held last column takes
    // the first pixel of a row, which writes nothing
    ram_we    = advance & (prim_we | tail_valid_q);
    ram_waddr = prim_we ? (col1_q - CW'(1)) : tail_col_q;
    ram_wdata = prim_we ? wr_left : tail_data_q;

    fill_d = fill_q;
    if (prim_we && WW'(col1_q) > fill_d) begin
      fill_d = WW'(col1_q);
    end
    if (tail_set && (WW'(col1_q) + WW'(1)) > fill_d) begin
      fill_d = WW'(col1_q) + WW'(1);
    end
    if (frame_end) begin
      fill_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      carry_q       <= '0;
      below_here_q  <= '0;
      below_ahead_q <= '0;
      tail_valid_q  <= 1'b0;
      fill_q        <= '0;
      fwd_hit_q     <= 1'b0;
    end else begin
      if (advance) begin
        carry_q <= lc1_q ? '0 : t7;
        if (lc1_q) begin
          below_here_q  <= '0;
          below_ahead_q <= '0;
        end else if (!lr1_q) begin
          below_here_q  <= cur;
          below_ahead_q <= t1;
        end
        if (tail_set) begin
          tail_valid_q <= 1'b1;
        end else if (col1_q == '0 || frame_end) begin
          tail_valid_q <= 1'b0;
        end
        fill_q <= fill_d;
      end
      // catch a write landing on the column being read in the same cycle
      if (accept) begin
        fwd_hit_q <= ram_we & ~(advance & frame_end) & (ram_waddr == col_cnt_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && tail_set) begin
      tail_col_q  <= col1_q;
      tail_data_q <= cur;
    end
    if (accept) begin
      fwd_data_q <= ram_wdata;
    end
  end

  // --------------------------------------------------------------------------
  // output register
  // --------------------------------------------------------------------------
  logic [PIX_W-1:0] pixel_out_q;
  logic             eor_q, eof_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      pixel_out_q <= white ? PIX_WHITE : PIX_BLACK;
      eor_q       <= lc1_q;
      eof_q       <= frame_end;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign pixel_out_o    = pixel_out_q;
  assign end_of_row_o   = eor_q;
  assign end_of_frame_o = eof_q;

`ifndef ASSERT_OFF
  // end of frame is always also end of row
  a_eof_eor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && end_of_frame_o |-> end_of_row_o)
    else $error("end_of_frame without end_of_row");

  // binarized output only
  a_pix_bin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (pixel_out_o == PIX_BLACK || pixel_out_o == PIX_WHITE))
    else $error("pixel_out not binary");

  // a held last-column error never outlives the first pixel of the next row
  a_tail_col0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && tail_valid_q |-> col1_q == '0)
    else $error("held error still pending past row start");

  // fill count stays within the buffer
  a_fill_rng: assert property (@(posedge clk_i) disable iff (!rst_ni)
    WW'(MAX_WIDTH) >= fill_q)
    else $error("fill count beyond buffer depth");
`endif

endmodule

/* sv/edd_ram.sv */
// ----------------------------------------------------------------------------
// edd_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; a read of the address being
// written returns the old contents.
// ----------------------------------------------------------------------------
module edd_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
